/* hdl/psa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package psa_pkg;
  localparam int unsigned NumColorsDef = 16;
  localparam int unsigned CellSizeDef = 4;
  localparam int unsigned SharedEndDef = 255;
  localparam int unsigned StampBitsDef = 24;
  localparam int unsigned RgbW = 18;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  color_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [23:0] current_frame;
  } req_t;

  typedef struct packed {
    logic [3:0]  logical_color;
    logic [7:0]  slot;
    logic        slot_written;
    logic [5:0]  slot_red;
    logic [5:0]  slot_green;
    logic [5:0]  slot_blue;
    logic [15:0] pending_mask;
    logic        video_changed;
    logic        last;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_NEXT, ST_MATCH, ST_AGE, ST_UNLOCK, ST_LOCK,
    ST_READ, ST_EMIT, ST_WAIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic clr_step;  // clear one slot
    logic pick;      // choose next color
    logic scan_rst;  // restart scan at private cell
    logic scan_adv;  // step scan
    logic to_age;    // restart scan of current cell for age pass
    logic take;      // slot found: keep its stamp, read old held stamp
    logic commit_w;  // write rgb+stamp at scan slot
    logic unlock;    // clear lock of old held slot
    logic lock;      // set lock on new slot, update held
    logic fail;      // color not placed
    logic rd_rgb;    // read rgb for result
    logic emit;      // form result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic have_color; // a color to handle
    logic hit;        // scan condition true at current slot
    logic scan_end;   // current slot is last of the current cell
    logic more_cell;  // shared cell still to scan
    logic last;
  } sts_t;
endpackage
`default_nettype wire

/* hdl/psa_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module psa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* hdl/psa_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module psa_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output psa_pkg::cmd_t  cmd_o,
  input  psa_pkg::sts_t  sts_i
);
  import psa_pkg::*;
  state_e state_q, state_d;
  logic   wait_q, wait_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  // Scan timing: RAM reads are registered, so each slot has an address cycle
  // and then a compare cycle; wait_q marks the compare cycle.
  // Order per color: private match, private age, shared match, shared age.
  always_comb begin
    state_d     = state_q;
    wait_d      = 1'b0;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        cmd_o.pick = 1'b1;
        cmd_o.scan_rst = 1'b1;
        if (sts_i.have_color) state_d = ST_MATCH;
        else state_d = ST_READ;
      end
      ST_MATCH, ST_AGE: begin
        if (!wait_q) begin
          wait_d = 1'b1;
        end else if (sts_i.hit) begin
          cmd_o.take = 1'b1;
          if (state_q == ST_AGE) cmd_o.commit_w = 1'b1;
          state_d = ST_UNLOCK;
        end else if (sts_i.scan_end) begin
          if (state_q == ST_MATCH) begin
            cmd_o.to_age = 1'b1;
            state_d = ST_AGE;
          end else if (sts_i.more_cell) begin
            cmd_o.scan_adv = 1'b1;
            state_d = ST_MATCH;
          end else begin
            cmd_o.fail = 1'b1;
            state_d = ST_READ;
          end
        end else begin
          cmd_o.scan_adv = 1'b1;
        end
      end
      ST_UNLOCK: begin
        cmd_o.unlock = 1'b1;
        state_d = ST_LOCK;
      end
      ST_LOCK: begin
        cmd_o.lock = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_rgb = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = sts_i.last ? ST_IDLE : ST_NEXT;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* hdl/psa_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module psa_dp #(
  parameter int unsigned NumColors = psa_pkg::NumColorsDef,
  parameter int unsigned CellSize  = psa_pkg::CellSizeDef,
  parameter int unsigned SharedEnd = psa_pkg::SharedEndDef,
  parameter int unsigned StampBits = psa_pkg::StampBitsDef
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  psa_pkg::req_t  req_i,
  input  psa_pkg::cmd_t  cmd_i,
  output psa_pkg::sts_t  sts_o,
  output psa_pkg::rsp_t  rsp_o
);
  import psa_pkg::*;
  localparam int unsigned FirstSlot = NumColors + 1;
  localparam int unsigned SharedLo  = FirstSlot + NumColors * CellSize;
  localparam int unsigned SharedHiC = (SharedEnd > 256) ? 256 : SharedEnd;
  localparam bit          SharedOk  = SharedLo < SharedHiC;
  localparam int unsigned StW = StampBits + 1;

  logic             refresh_q;
  logic [3:0]       cidx_q;
  logic [RgbW-1:0]  rgb_in_q;
  logic [StampBits-1:0] stamp_q, thr_q;
  logic [StampBits-1:0] lkst_q;  // stamp bits of the found slot
  logic [15:0]      pend_q;
  logic [RgbW-1:0]  prgb_q [16];
  logic [7:0]       held_q [16];
  logic [4:0]       cur_q;      // color under work
  logic             act_q;      // color handled (in range / pending)
  logic             any_q;      // refresh produced a result
  logic [7:0]       slot_q;     // scan position
  logic             shared_q;   // scanning shared cell
  logic [7:0]       res_q;      // found slot
  logic             wrote_q;
  logic [8:0]       clr_q;
  rsp_t             rsp_q;

  // RAMs
  logic            pal_we, st_we;
  logic [7:0]      pal_wa, st_wa, pal_ra, st_ra;
  logic [RgbW-1:0] pal_wd, pal_rd;
  logic [StW-1:0]  st_wd, st_rd;
  logic [RgbW-1:0] rgb_cur;

  psa_ram #(.Width(RgbW), .Depth(256)) u_pal (
    .clk_i, .we_i(pal_we), .waddr_i(pal_wa), .wdata_i(pal_wd),
    .raddr_i(pal_ra), .rdata_o(pal_rd));
  psa_ram #(.Width(StW), .Depth(256)) u_stamp (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd),
    .raddr_i(st_ra), .rdata_o(st_rd));

  logic [3:0] c4;
  assign c4 = cur_q[3:0];
  assign rgb_cur = refresh_q ? prgb_q[c4] : rgb_in_q;

  // private cell bounds for current color
  logic [8:0] priv_lo, priv_last;
  assign priv_lo   = 9'(FirstSlot + 32'(c4) * CellSize);
  assign priv_last = 9'(32'(priv_lo) + CellSize - 1);

  // next pending color at or after cur (narrow 16-entry priority search)
  logic [4:0] nxt;
  logic       nxt_ok;
  always_comb begin
    nxt = 5'd16;
    nxt_ok = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (i < NumColors && pend_q[i] && 5'(i) >= cur_q) begin
        nxt = 5'(i);
        nxt_ok = 1'b1;
      end
    end
  end

  logic priv_end;
  assign priv_end = {1'b0, slot_q} == priv_last;
  logic mhit, ahit;
  assign mhit = pal_rd == rgb_cur;
  assign ahit = st_rd <= {1'b0, thr_q};

  // match vs age selected by whether a stamp compare is in use
  logic age_mode_q;

  logic hit_now;
  assign hit_now = age_mode_q ? ahit : mhit;

  always_comb begin
    sts_o = '0;
    sts_o.clr_done   = clr_q == 9'd255;
    sts_o.have_color = refresh_q ? nxt_ok : (32'(cidx_q) < NumColors);
    sts_o.hit        = hit_now;
    sts_o.scan_end   = shared_q ? ({1'b0, slot_q} == 9'(SharedHiC - 1)) : priv_end;
    sts_o.more_cell  = !shared_q && SharedOk;
    sts_o.last       = !refresh_q || !nxt_ok || !any_q ? 1'b1 : 1'b0;
  end

  // read address tracks the scan slot; on a find, fetch the old held stamp
  assign pal_ra = cmd_i.rd_rgb ? res_q : slot_q;
  assign st_ra  = cmd_i.take ? held_q[c4] : slot_q;

  always_comb begin
    pal_we = 1'b0; pal_wa = slot_q; pal_wd = rgb_cur;
    st_we = 1'b0;  st_wa = slot_q;  st_wd = {1'b0, stamp_q};
    if (cmd_i.clr_step) begin
      pal_we = 1'b1; pal_wa = clr_q[7:0]; pal_wd = '0;
      st_we = 1'b1;  st_wa = clr_q[7:0];  st_wd = '0;
    end else if (cmd_i.commit_w) begin
      pal_we = 1'b1; st_we = 1'b1;
    end else if (cmd_i.unlock) begin
      st_we = 1'b1; st_wa = held_q[c4]; st_wd = {1'b0, st_rd[StampBits-1:0]};
    end else if (cmd_i.lock) begin
      st_we = 1'b1; st_wa = res_q; st_wd = {1'b1, lkst_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      clr_q  <= '0;
      for (int i = 0; i < 16; i++) held_q[i] <= '0;
    end else begin
      if (cmd_i.clr_step && clr_q != 9'd255) clr_q <= clr_q + 9'd1;
      if (cmd_i.lock) held_q[c4] <= res_q;
      if (cmd_i.lock) pend_q[c4] <= 1'b0;
      if (cmd_i.fail && !refresh_q) pend_q[c4] <= 1'b1;
    end
  end

  logic [StampBits-1:0] fr;
  assign fr = StampBits'(req_i.current_frame);
  // unlock uses the held-slot stamp read on the find cycle; lock uses the
  // stamp bits kept from the found slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      refresh_q <= req_i.req_type;
      cidx_q    <= req_i.color_index;
      rgb_in_q  <= {req_i.red_in[7:2], req_i.green_in[7:2], req_i.blue_in[7:2]};
      stamp_q   <= fr;
      if (req_i.req_type)
        thr_q <= (fr >= StampBits'(2)) ? fr - StampBits'(2) : '0;
      else
        thr_q <= (fr >= StampBits'(3)) ? fr - StampBits'(3) : '0;
      cur_q     <= '0;
      any_q     <= 1'b0;
    end
    if (cmd_i.pick) begin
      if (refresh_q) cur_q <= nxt_ok ? nxt : 5'd16;
      else cur_q <= {1'b0, cidx_q};
      act_q      <= sts_o.have_color;
      res_q      <= '0;
      wrote_q    <= 1'b0;
      age_mode_q <= 1'b0;
    end
    if (cmd_i.scan_rst) begin
      shared_q <= 1'b0;
      slot_q   <= refresh_q ? 8'(FirstSlot + 32'(nxt[3:0]) * CellSize) :
                  8'(FirstSlot + 32'(cidx_q) * CellSize);
    end
    if (cmd_i.to_age) begin
      slot_q     <= shared_q ? 8'(SharedLo) : priv_lo[7:0];
      age_mode_q <= 1'b1;
    end
    if (cmd_i.scan_adv) begin
      if (!shared_q && priv_end) begin
        shared_q   <= 1'b1;
        slot_q     <= 8'(SharedLo);
        age_mode_q <= 1'b0;
      end else slot_q <= slot_q + 8'd1;
    end
    if (cmd_i.take) lkst_q <= cmd_i.commit_w ? stamp_q : st_rd[StampBits-1:0];
    if (cmd_i.commit_w) wrote_q <= 1'b1;
    if (cmd_i.unlock) res_q <= slot_q;
    if (cmd_i.fail && !refresh_q) prgb_q[c4] <= rgb_in_q;
    if (cmd_i.emit) begin
      rsp_q.logical_color <= act_q ? c4 : (refresh_q ? 4'd0 : cidx_q);
      rsp_q.slot          <= res_q;
      rsp_q.slot_written  <= wrote_q;
      rsp_q.slot_red      <= res_q != 0 ? pal_rd[17:12] : 6'd0;
      rsp_q.slot_green    <= res_q != 0 ? pal_rd[11:6] : 6'd0;
      rsp_q.slot_blue     <= res_q != 0 ? pal_rd[5:0] : 6'd0;
      rsp_q.pending_mask  <= pend_q;
      rsp_q.video_changed <= refresh_q && res_q != 0;
      rsp_q.last          <= 1'b0;
      any_q <= 1'b1;
      if (refresh_q && act_q) cur_q <= cur_q + 5'd1;
    end
  end
  assign rsp_o = rsp_q;
endmodule
`default_nettype wire

/* hdl/palette_slot_allocator_with_aging.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel  | dir | handshake            | payload
// request  | in  | in_valid_i/in_ready_o | in_data_i (req_t)
// result   | out | out_valid_o/out_ready_i | out_data_o (rsp_t)
// A color scans its private cell (match, then age) and then the shared cell
// (match, then age), each slot addressed and then compared through the registered
// palette and stamp RAMs; a refresh handles each pending color in turn, with one
// result per color.
// After reset a clearing pass zeroes all 256 entries of both RAMs; no request is
// taken meanwhile. A stalled result holds the block until taken.
module palette_slot_allocator_with_aging #(
  parameter int unsigned NumColors = psa_pkg::NumColorsDef,
  parameter int unsigned CellSize  = psa_pkg::CellSizeDef,
  parameter int unsigned SharedEnd = psa_pkg::SharedEndDef,
  parameter int unsigned StampBits = psa_pkg::StampBitsDef
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  psa_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output psa_pkg::rsp_t  out_data_o
);
  import psa_pkg::*;
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  psa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts));

  psa_dp #(.NumColors(NumColors), .CellSize(CellSize), .SharedEnd(SharedEnd),
           .StampBits(StampBits)) u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts),
    .rsp_o(rsp));

  // last flag: final result of this request
  always_comb begin
    out_data_o = rsp;
    out_data_o.last = sts.last;
  end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import psa_pkg::*;

  localparam int unsigned NCOL = NumColorsDef;
  localparam int unsigned CELL = CellSizeDef;
  localparam int unsigned SEND = SharedEndDef;
  localparam int unsigned SBITS = StampBitsDef;
  localparam int unsigned FIRST = NCOL + 1;
  localparam int unsigned SH_LO = FIRST + NCOL * CELL;
  localparam logic [24:0] LOCK = 25'(1) << SBITS;
  localparam logic [24:0] SMASK = LOCK - 25'(1);
  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_REFRESH = 1'b1;
  localparam longint CYCLE_LIMIT = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  always #2 clk_i = ~clk_i;

  palette_slot_allocator_with_aging u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // shadow of the allocator state
  logic [17:0] pal_rgb [256];
  logic [24:0] pal_stamp [256];
  logic [7:0]  own_slot [16];
  logic [17:0] wait_rgb [16];
  logic [15:0] wait_bits;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  longint cycles = 0;
  bit   stim_done = 1'b0;
  bit   no_idle = 1'b0;     // idle-free stretch
  int   hold_rx = 0;        // receiver hold-off, in cycles
  bit   tx_pause = 1'b0;    // sender waits for drain

  task automatic report(input string what, input rsp_t got, input rsp_t exp);
    errors++;
    $display("mismatch %s: got %h exp %h", what, got, exp);
  endtask

  // scan one cell: RGB match first, then the oldest-enough unlocked slot
  function automatic int unsigned scan(int unsigned lo, int unsigned hi,
      logic [17:0] rgb, logic [24:0] thr, logic [24:0] stamp, ref bit wrote);
    int unsigned top;
    top = (hi > 256) ? 256 : hi;
    for (int unsigned i = lo; i < top; i++)
      if (pal_rgb[i] == rgb) return i;
    for (int unsigned i = lo; i < top; i++)
      if (pal_stamp[i] <= thr) begin
        pal_rgb[i] = rgb;
        pal_stamp[i] = stamp;
        wrote = 1'b1;
        return i;
      end
    return 0;
  endfunction

  function automatic int unsigned place_color(int unsigned c, logic [17:0] rgb,
      logic [24:0] thr, logic [24:0] stamp, ref bit wrote);
    int unsigned lo, s;
    lo = FIRST + c * CELL;
    s = scan(lo, lo + CELL, rgb, thr, stamp, wrote);
    if (s == 0) s = scan(SH_LO, SEND, rgb, thr, stamp, wrote);
    if (s == 0) return 0;
    pal_stamp[own_slot[c]] &= ~LOCK;
    own_slot[c] = 8'(s);
    pal_stamp[s] |= LOCK;
    return s;
  endfunction

  function automatic rsp_t make_rsp(int unsigned c, int unsigned s, bit wrote, bit vid);
    rsp_t r;
    logic [17:0] rgb;
    rgb = s ? pal_rgb[s] : '0;
    r.logical_color = 4'(c);
    r.slot = 8'(s);
    r.slot_written = wrote;
    r.slot_red = rgb[17:12];
    r.slot_green = rgb[11:6];
    r.slot_blue = rgb[5:0];
    r.pending_mask = wait_bits;
    r.video_changed = vid;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic predict_allocation(input req_t q);
    logic [24:0] stamp, thr;
    logic [17:0] rgb;
    int unsigned c, s, n;
    bit wrote;
    rsp_t r;
    stamp = 25'(q.current_frame) & SMASK;
    n = 0;
    if (q.req_type == REQ_SET) begin
      c = q.color_index;
      rgb = {q.red_in[7:2], q.green_in[7:2], q.blue_in[7:2]};
      thr = (stamp >= 3) ? stamp - 3 : '0;
      wrote = 1'b0;
      s = 0;
      if (c < NCOL) begin
        s = place_color(c, rgb, thr, stamp, wrote);
        if (s != 0) wait_bits[c] = 1'b0;
        else begin
          wait_rgb[c] = rgb;
          wait_bits[c] = 1'b1;
        end
      end
      r = make_rsp(c, s, wrote, 1'b0);
      r.last = 1'b1;
      expected_rsps.push_back(r);
    end else begin
      thr = (stamp >= 2) ? stamp - 2 : '0;
      for (c = 0; c < NCOL; c++) begin
        if (!wait_bits[c]) continue;
        wrote = 1'b0;
        s = place_color(c, wait_rgb[c], thr, stamp, wrote);
        if (s != 0) wait_bits[c] = 1'b0;
        expected_rsps.push_back(make_rsp(c, s, wrote, s != 0));
        n++;
      end
      if (n == 0) expected_rsps.push_back(make_rsp(0, 0, 1'b0, 1'b0));
      expected_rsps[$].last = 1'b1;
    end
  endtask

  function automatic req_t mk_req(logic t, logic [3:0] c, logic [7:0] r,
      logic [7:0] g, logic [7:0] b, logic [23:0] f);
    req_t q;
    q.req_type = t;
    q.color_index = c;
    q.red_in = r;
    q.green_in = g;
    q.blue_in = b;
    q.current_frame = f;
    return q;
  endfunction

  // driver: next request out of the queue, random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_allocation(in_data_i);
      if (!(in_valid_i && !in_ready_o)) begin
        if (pending_reqs.size() != 0 && !tx_pause &&
            (no_idle || $urandom_range(99) >= 15)) begin
          in_data_i <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare results against the expected list
  always @(posedge clk_i) begin
    rsp_t exp, got;
    cycles++;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (expected_rsps.size() == 0) begin
          report("unexpected", got, '0);
        end else begin
          exp = expected_rsps.pop_front();
          if (got.logical_color !== exp.logical_color) report("color", got, exp);
          if (got.slot !== exp.slot) report("slot", got, exp);
          if (got.slot_written !== exp.slot_written) report("written", got, exp);
          if ({got.slot_red, got.slot_green, got.slot_blue} !==
              {exp.slot_red, exp.slot_green, exp.slot_blue}) report("rgb", got, exp);
          if (got.pending_mask !== exp.pending_mask) report("pending", got, exp);
          if (got.video_changed !== exp.video_changed) report("video", got, exp);
          if (got.last !== exp.last) report("last", got, exp);
        end
      end
      if (hold_rx > 0) begin
        hold_rx <= hold_rx - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 15);
      end
    end
  end

  task automatic wait_drain();
    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      pal_rgb[i] = '0;
      pal_stamp[i] = '0;
    end
    for (int i = 0; i < 16; i++) begin
      own_slot[i] = '0;
      wait_rgb[i] = '0;
    end
    wait_bits = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, refresh with nothing pending, frame below offsets
    pending_reqs.push_back(mk_req(REQ_REFRESH, 4'h0, 8'h00, 8'h00, 8'h00, 24'd0));
    pending_reqs.push_back(mk_req(REQ_SET, 4'h0, 8'hff, 8'hff, 8'hff, 24'd0));
    pending_reqs.push_back(mk_req(REQ_SET, 4'hf, 8'h00, 8'h00, 8'h00, 24'd1));
    pending_reqs.push_back(mk_req(REQ_SET, 4'h5, 8'h03, 8'hfc, 8'h80, 24'd2));
    pending_reqs.push_back(mk_req(REQ_SET, 4'h5, 8'h03, 8'hfc, 8'h80, 24'd3));
    pending_reqs.push_back(mk_req(REQ_SET, 4'ha, 8'h12, 8'h34, 8'h56, 24'hffffff));
    pending_reqs.push_back(mk_req(REQ_REFRESH, 4'hf, 8'hff, 8'hff, 8'hff, 24'hffffff));
    // flood one frame with sets for colors 0 to 13
    for (int i = 0; i < 14; i++)
      pending_reqs.push_back(mk_req(REQ_SET, 4'(i), 8'(i * 17), 8'(i * 5),
                                    8'(255 - i), 24'd100));
    pending_reqs.push_back(mk_req(REQ_REFRESH, 4'h0, 8'h0, 8'h0, 8'h0, 24'd101));
    pending_reqs.push_back(mk_req(REQ_REFRESH, 4'h0, 8'h0, 8'h0, 8'h0, 24'd200));
    wait_drain();

    // long receiver hold-off while the sender keeps offering
    no_idle = 1'b1;
    hold_rx = 3000;
    for (int i = 0; i < 6; i++)
      pending_reqs.push_back(mk_req(REQ_SET, 4'($urandom_range(15)), 8'($urandom),
                                    8'($urandom), 8'($urandom), 24'd300));
    wait_drain();
    no_idle = 1'b0;

    // random: mostly sets in a slowly advancing frame, few red and green levels in
    // half of the sets to force reuse and sharing, occasional refreshes and frame jumps
    begin
      logic [23:0] frame;
      frame = 24'd400;
      for (int k = 0; k < 250; k++) begin
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8) frame = 24'($urandom);
        else if (sel < 40) frame = frame + 24'($urandom_range(3));
        if (k == 120) begin
          while (pending_reqs.size() != 0) @(posedge clk_i);
          tx_pause = 1'b1;
          wait_drain();
          tx_pause = 1'b0;
        end
        no_idle = (k >= 150 && k < 190);
        if ($urandom_range(99) < 15)
          pending_reqs.push_back(mk_req(REQ_REFRESH, 4'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom), frame));
        else if ($urandom_range(1))
          pending_reqs.push_back(mk_req(REQ_SET, 4'($urandom), 8'($urandom_range(3) * 64),
                                        8'($urandom_range(3) * 64), 8'($urandom), frame));
        else
          pending_reqs.push_back(mk_req(REQ_SET, 4'($urandom), 8'($urandom),
                                        8'($urandom), 8'($urandom), frame));
      end
    end
    wait_drain();
    repeat (2000) @(posedge clk_i);
    stim_done = 1'b1;
  end

  initial begin
    while (!stim_done && cycles < CYCLE_LIMIT) @(posedge clk_i);
    if (!stim_done) begin
      $display("FAILURE");
      $finish;
    end else begin
      if (errors == 0 && expected_rsps.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
    end
  end
endmodule
